// File: hw/rtl/porter_duff_alpha_blend_core_assert.svh
// Assertion macros for the alpha blend core.
// Each macro expects clk and rst_n in scope.
`ifndef PORTER_DUFF_ALPHA_BLEND_CORE_ASSERT_SVH
`define PORTER_DUFF_ALPHA_BLEND_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define PDAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define PDAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PDAB_ASSERT_IMP(lbl, ante, cons, msg)
`define PDAB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/pdab_pkg.sv
`default_nettype none
package pdab_pkg;

  // Pipeline shape
  localparam int unsigned N_STAGES    = 8;
  localparam int unsigned LANE_STAGES = 5;
  localparam int unsigned DIV_STEPS   = 4;
  localparam int unsigned Q_W         = 8;

  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef logic [7:0] pix_t;

  // Per-stage enables handed to a divider lane
  typedef logic [LANE_STAGES-1:0] lane_en_t;

  // Side data that travels alongside the divider lanes
  typedef struct packed {
    logic       opaque;
    logic       zero;
    pix_t       alpha;
    pix_t [2:0] mix;
  } side_t;

  // One restoring division step
  typedef struct packed {
    logic [23:0] rem;
    logic        q;
  } div_bit_t;

  // floor(x / 255), exact for x up to 65025
  function automatic pix_t div255(input logic [15:0] x);
    logic [15:0] s;
    s = x + 16'd1 + {8'd0, x[15:8]};
    return s[15:8];
  endfunction

  function automatic div_bit_t div_bit(input logic [23:0] rem, input logic [23:0] dsh);
    div_bit_t r;
    if (rem >= dsh) begin
      r.rem = rem - dsh;
      r.q   = 1'b1;
    end else begin
      r.rem = rem;
      r.q   = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pdab_div_lane.sv
`default_nettype none
// Pipelined restoring divider for one colour channel:
// quo = min(255, floor(num / (255 * oa))), two quotient bits per stage.
module pdab_div_lane (
  input  wire logic              clk,
  input  wire pdab_pkg::lane_en_t en_i,
  input  wire logic [24:0]       num_i,
  input  wire pdab_pkg::pix_t    oa_i,
  output pdab_pkg::pix_t         quo_o
);
  import pdab_pkg::*;

  logic [15:0]    den_nxt;
  logic           sat_nxt;
  logic [15:0]    den_r [0:DIV_STEPS];
  logic [23:0]    rem_r [0:DIV_STEPS];
  logic           sat_r [0:DIV_STEPS];
  logic [Q_W-1:0] q_r   [1:DIV_STEPS];

  // Divisor 255*oa; quotient of 256 or more saturates
  assign den_nxt = {oa_i, 8'd0} - {8'd0, oa_i};
  assign sat_nxt = num_i >= {1'b0, den_nxt, 8'd0};

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      den_r[0] <= den_nxt;
      rem_r[0] <= num_i[23:0];
      sat_r[0] <= sat_nxt;
    end
  end

  // Division steps, high quotient bits first
  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    localparam int unsigned HI = Q_W - 1 - 2 * (s - 1);
    localparam int unsigned LO = HI - 1;
    logic [23:0]    d24;
    div_bit_t       st_hi;
    div_bit_t       st_lo;
    logic [Q_W-1:0] q_base;
    logic [Q_W-1:0] q_nxt;

    always_comb begin
      d24   = {8'd0, den_r[s-1]};
      st_hi = div_bit(rem_r[s-1], d24 << HI);
      st_lo = div_bit(st_hi.rem, d24 << LO);
      q_nxt = q_base;
      q_nxt[HI] = st_hi.q;
      q_nxt[LO] = st_lo.q;
    end

    if (s == 1) begin : g_first
      assign q_base = '0;
    end else begin : g_rest
      assign q_base = q_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en_i[s]) begin
        den_r[s] <= den_r[s-1];
        rem_r[s] <= st_lo.rem;
        sat_r[s] <= sat_r[s-1];
        q_r[s]   <= q_nxt;
      end
    end
  end

  assign quo_o = sat_r[DIV_STEPS] ? PIX_MAX : q_r[DIV_STEPS];

endmodule
`default_nettype wire

// File: hw/rtl/porter_duff_alpha_blend_core.sv
`default_nettype none
// Porter-Duff "over" blend of a foreground RGBA pixel onto a background
// RGBA pixel. Both pixels opaque: linear mix by mix_factor, alpha 255.
// Otherwise oa = fa + floor((255-fa)*ba/255) and each channel is
// floor((255*fa*f + (255-fa)*ba*b) / (255*oa)) saturated at 255, zero when
// oa is zero. One pixel per clock while the output is not stalled; the
// pipeline depth is set by the restoring dividers of the three colour
// channels, which resolve two quotient bits per stage. A stalled output
// holds its result while empty stages upstream keep filling.
module porter_duff_alpha_blend_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pdab_pkg::pix_t in_bg_red,
  input  wire pdab_pkg::pix_t in_bg_green,
  input  wire pdab_pkg::pix_t in_bg_blue,
  input  wire pdab_pkg::pix_t in_bg_alpha,
  input  wire pdab_pkg::pix_t in_fg_red,
  input  wire pdab_pkg::pix_t in_fg_green,
  input  wire pdab_pkg::pix_t in_fg_blue,
  input  wire pdab_pkg::pix_t in_fg_alpha,
  input  wire pdab_pkg::pix_t in_mix_factor,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pdab_pkg::pix_t      out_red,
  output pdab_pkg::pix_t      out_green,
  output pdab_pkg::pix_t      out_blue,
  output pdab_pkg::pix_t      out_alpha
);
  import pdab_pkg::*;
  `include "porter_duff_alpha_blend_core_assert.svh"

  // Handshake state
  logic [N_STAGES-1:0] v_r;
  logic [N_STAGES-1:0] v_nxt;
  logic [N_STAGES:0]   en;

  // Stage 0: products
  pix_t        bg_c  [3];
  pix_t        fg_c  [3];
  logic [15:0] pff_r [3];
  logic [15:0] mixs_r[3];
  pix_t        bch_r [3];
  logic [15:0] wab_r;
  pix_t        fa0_r;
  logic        opq0_r;

  // Stage 1: numerators and side data
  logic [24:0] num1_r[3];
  pix_t        oa1_c;
  side_t       side_nxt;
  side_t       side_r[1:LANE_STAGES+1];

  // Lane outputs and result register
  pix_t        quo[3];
  pix_t        ch_r[3];
  pix_t        alpha_r;

  assign bg_c[0] = in_bg_red;
  assign bg_c[1] = in_bg_green;
  assign bg_c[2] = in_bg_blue;
  assign fg_c[0] = in_fg_red;
  assign fg_c[1] = in_fg_green;
  assign fg_c[2] = in_fg_blue;

  // Stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[N_STAGES] = out_ready;
    for (int k = N_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign v_nxt    = {v_r[N_STAGES-2:0], in_valid};
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  // Stage 0: 8x8 products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 3; c++) begin
        pff_r[c]  <= in_fg_alpha * fg_c[c];
        mixs_r[c] <= in_mix_factor * fg_c[c] + (PIX_MAX - in_mix_factor) * bg_c[c];
        bch_r[c]  <= bg_c[c];
      end
      wab_r  <= (PIX_MAX - in_fg_alpha) * in_bg_alpha;
      fa0_r  <= in_fg_alpha;
      opq0_r <= (in_fg_alpha == PIX_MAX) && (in_bg_alpha == PIX_MAX);
    end
  end

  // Stage 1: composite alpha, channel numerators, opaque mix
  always_comb begin
    oa1_c           = fa0_r + div255(wab_r);
    side_nxt.opaque = opq0_r;
    side_nxt.zero   = (oa1_c == 8'd0);
    side_nxt.alpha  = oa1_c;
    for (int c = 0; c < 3; c++) begin
      side_nxt.mix[c] = div255(mixs_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int c = 0; c < 3; c++) begin
        // background term needs the full 24-bit product
        num1_r[c] <= ({9'd0, pff_r[c]} << 8) - {9'd0, pff_r[c]}
                     + {1'b0, {8'd0, wab_r} * {16'd0, bch_r[c]}};
      end
      side_r[1] <= side_nxt;
    end
  end

  // Side data shift line alongside the dividers
  for (genvar k = 2; k <= LANE_STAGES + 1; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Dividers, one lane per colour channel
  for (genvar c = 0; c < 3; c++) begin : g_lane
    pdab_div_lane u_lane (
      .clk   (clk),
      .en_i  (en[LANE_STAGES+1:2]),
      .num_i (num1_r[c]),
      .oa_i  (side_r[1].alpha),
      .quo_o (quo[c])
    );
  end

  // Result register: pick the path per pixel
  always_ff @(posedge clk) begin
    if (en[N_STAGES-1]) begin
      for (int c = 0; c < 3; c++) begin
        if (side_r[LANE_STAGES+1].opaque) begin
          ch_r[c] <= side_r[LANE_STAGES+1].mix[c];
        end else if (side_r[LANE_STAGES+1].zero) begin
          ch_r[c] <= 8'd0;
        end else begin
          ch_r[c] <= quo[c];
        end
      end
      alpha_r <= side_r[LANE_STAGES+1].opaque ? PIX_MAX : side_r[LANE_STAGES+1].alpha;
    end
  end

  assign out_valid = v_r[N_STAGES-1];
  assign out_red   = ch_r[0];
  assign out_green = ch_r[1];
  assign out_blue  = ch_r[2];
  assign out_alpha = alpha_r;

  // Checks
  `PDAB_ASSERT_IMP(a_stall_full, !in_ready, &v_r, "input stalled with a bubble in the pipe")
  `PDAB_ASSERT_NXT(a_take_lands, in_valid && in_ready, v_r[0], "input transfer not captured")
  `PDAB_ASSERT_NXT(a_mid_hold, v_r[3] && !en[3], v_r[3] && $stable(side_r[3]), "held stage lost data")
  `PDAB_ASSERT_IMP(a_zero_alpha, out_valid && (out_alpha == 8'd0), (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0), "colour not zero at zero alpha")

endmodule
`default_nettype wire

// File: dv/porter_duff_alpha_blend_core_tb.sv
`default_nettype none
module porter_duff_alpha_blend_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdab_pkg::*;

  localparam int unsigned FULL            = 255;
  localparam int unsigned RANDOM_PIXELS   = 1630;
  localparam int unsigned DRAIN_CYCLES    = 2 * N_STAGES;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_OFF_AFTER  = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  // one input transfer: background, foreground and mix weight
  typedef struct packed {
    pix_t bg_red;
    pix_t bg_green;
    pix_t bg_blue;
    pix_t bg_alpha;
    pix_t fg_red;
    pix_t fg_green;
    pix_t fg_blue;
    pix_t fg_alpha;
    pix_t mix_factor;
  } pixel_pair_t;

  // one blended result
  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    pix_t alpha;
  } blend_px_t;

  typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_TOGGLE} ready_mode_t;

  // Predicts each blended pixel and matches results against them in order
  class blend_scoreboard;
    blend_px_t   blends_due[$];
    int unsigned pixels_in;
    int unsigned pixels_out;
    int unsigned errors;
    int unsigned opaque_mixes;
    int unsigned over_blends;
    int unsigned clear_blends;
    int unsigned clamped_lanes;

    // linear mix on the opaque path
    function int unsigned mix_lane(input int unsigned m, input int unsigned f,
                                   input int unsigned b);
      return (m * f + (FULL - m) * b) / FULL;
    endfunction

    // alpha-weighted colour on the over path, saturated
    function int unsigned over_lane(input int unsigned b, input int unsigned ba,
                                    input int unsigned f, input int unsigned fa,
                                    input int unsigned oa);
      int unsigned num;
      int unsigned q;
      if (oa == 0) return 0;
      num = FULL * fa * f + (FULL - fa) * ba * b;
      q   = num / (FULL * oa);
      if (q > FULL) begin
        clamped_lanes++;
        return FULL;
      end
      return q;
    endfunction

    function blend_px_t blend_over(input pixel_pair_t p);
      blend_px_t   r;
      int unsigned fa;
      int unsigned ba;
      int unsigned oa;
      fa = p.fg_alpha;
      ba = p.bg_alpha;
      if (fa == FULL && ba == FULL) begin
        opaque_mixes++;
        r.red   = pix_t'(mix_lane(p.mix_factor, p.fg_red, p.bg_red));
        r.green = pix_t'(mix_lane(p.mix_factor, p.fg_green, p.bg_green));
        r.blue  = pix_t'(mix_lane(p.mix_factor, p.fg_blue, p.bg_blue));
        r.alpha = PIX_MAX;
      end else begin
        oa = fa + ((FULL - fa) * ba) / FULL;
        if (oa == 0) clear_blends++;
        else over_blends++;
        r.red   = pix_t'(over_lane(p.bg_red, ba, p.fg_red, fa, oa));
        r.green = pix_t'(over_lane(p.bg_green, ba, p.fg_green, fa, oa));
        r.blue  = pix_t'(over_lane(p.bg_blue, ba, p.fg_blue, fa, oa));
        r.alpha = pix_t'(oa);
      end
      return r;
    endfunction

    function void note_pixel(input pixel_pair_t p);
      pixels_in++;
      blends_due.push_back(blend_over(p));
    endfunction

    function void compare_lane(input string lane, input pix_t want, input pix_t got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch on pixel %0d, expected %0d, actual %0d",
                 $time, lane, pixels_out, want, got);
      end
    endfunction

    function void check_blend(input blend_px_t got);
      blend_px_t want;
      pixels_out++;
      if (blends_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = blends_due.pop_front();
      compare_lane("red", want.red, got.red);
      compare_lane("green", want.green, got.green);
      compare_lane("blue", want.blue, got.blue);
      compare_lane("alpha", want.alpha, got.alpha);
    endfunction

    function int unsigned outstanding();
      return blends_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  pix_t        in_bg_red     = '0;
  pix_t        in_bg_green   = '0;
  pix_t        in_bg_blue    = '0;
  pix_t        in_bg_alpha   = '0;
  pix_t        in_fg_red     = '0;
  pix_t        in_fg_green   = '0;
  pix_t        in_fg_blue    = '0;
  pix_t        in_fg_alpha   = '0;
  pix_t        in_mix_factor = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  pix_t        out_red;
  pix_t        out_green;
  pix_t        out_blue;
  pix_t        out_alpha;
  int unsigned cycle_count   = 0;

  blend_scoreboard sb = new;

  porter_duff_alpha_blend_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_bg_red     (in_bg_red),
    .in_bg_green   (in_bg_green),
    .in_bg_blue    (in_bg_blue),
    .in_bg_alpha   (in_bg_alpha),
    .in_fg_red     (in_fg_red),
    .in_fg_green   (in_fg_green),
    .in_fg_blue    (in_fg_blue),
    .in_fg_alpha   (in_fg_alpha),
    .in_mix_factor (in_mix_factor),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timed out, %0d pixels still outstanding", $time, sb.outstanding());
    $display("FAIL");
    $finish;
  end

  function automatic pixel_pair_t make_pixel(input pix_t br, input pix_t bgc, input pix_t bb,
                                             input pix_t ba, input pix_t fr, input pix_t fgc,
                                             input pix_t fb, input pix_t fa, input pix_t m);
    return '{br, bgc, bb, ba, fr, fgc, fb, fa, m};
  endfunction

  // alpha pairs weighted towards the opaque path and the edges of the over path
  function automatic pixel_pair_t random_pixel();
    pixel_pair_t p;
    p = pixel_pair_t'(72'({$urandom, $urandom, $urandom}));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        p.bg_alpha = PIX_MAX;
        p.fg_alpha = PIX_MAX;
      end
      3: begin
        p.bg_alpha = '0;
        p.fg_alpha = '0;
      end
      4: p.fg_alpha = PIX_MAX;
      5: p.fg_alpha = '0;
      6: p.bg_alpha = PIX_MAX;
      7: p.bg_alpha = '0;
      default: ;
    endcase
    // flat colours make saturation and the mix extremes likely
    case ($urandom_range(0, 7))
      0: {p.bg_red, p.bg_green, p.bg_blue, p.fg_red, p.fg_green, p.fg_blue} = '1;
      1: begin
        {p.fg_red, p.fg_green, p.fg_blue} = '1;
        {p.bg_red, p.bg_green, p.bg_blue} = '0;
      end
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) p.mix_factor = $urandom_range(0, 1) ? PIX_MAX : '0;
    return p;
  endfunction

  // offer one pixel and hold it until the transfer
  task automatic send_pixel(input pixel_pair_t p);
    in_valid      <= 1'b1;
    in_bg_red     <= p.bg_red;
    in_bg_green   <= p.bg_green;
    in_bg_blue    <= p.bg_blue;
    in_bg_alpha   <= p.bg_alpha;
    in_fg_red     <= p.fg_red;
    in_fg_green   <= p.fg_green;
    in_fg_blue    <= p.fg_blue;
    in_fg_alpha   <= p.fg_alpha;
    in_mix_factor <= p.mix_factor;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(p);
  endtask

  // receiver: stall pattern in windows, plus one long hold-off mid-run
  initial begin
    blend_px_t   got;
    ready_mode_t mode;
    int unsigned window_left;
    int unsigned hold_left;
    bit          held;
    mode        = READY_ALWAYS;
    window_left = 0;
    hold_left   = 0;
    held        = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{out_red, out_green, out_blue, out_alpha};
        sb.check_blend(got);
      end
      if (!held && sb.pixels_in >= HOLD_OFF_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (window_left == 0) begin
          mode        = ready_mode_t'($urandom_range(0, 3));
          window_left = $urandom_range(16, 96);
        end
        window_left--;
        case (mode)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          READY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
          default:      out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // sender
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255, 255, 255));
    send_pixel(make_pixel(0, 0, 0, 255, 255, 255, 255, 255, 0));
    send_pixel(make_pixel(0, 0, 0, 255, 255, 255, 255, 255, 255));
    send_pixel(make_pixel(10, 20, 30, 255, 200, 100, 50, 255, 128));
    send_pixel(make_pixel(0, 255, 85, 255, 255, 0, 170, 255, 1));
    send_pixel(make_pixel(255, 0, 85, 255, 0, 255, 170, 255, 254));
    // one or both alphas zero, mix ignored
    send_pixel(make_pixel(255, 255, 255, 0, 255, 255, 255, 0, 255));
    send_pixel(make_pixel(12, 34, 56, 0, 78, 90, 123, 255, 7));
    send_pixel(make_pixel(12, 34, 56, 255, 78, 90, 123, 0, 7));
    send_pixel(make_pixel(255, 255, 255, 1, 255, 255, 255, 0, 0));
    send_pixel(make_pixel(255, 255, 255, 0, 255, 255, 255, 1, 0));
    // floored alpha pushes the colour quotient over full scale
    send_pixel(make_pixel(255, 255, 255, 128, 255, 255, 255, 1, 0));
    send_pixel(make_pixel(255, 255, 255, 200, 255, 255, 255, 127, 0));
    send_pixel(make_pixel(1, 2, 3, 255, 250, 251, 252, 254, 99));
    send_pixel(make_pixel(250, 251, 252, 254, 1, 2, 3, 255, 99));
    send_pixel(make_pixel(200, 100, 0, 128, 0, 100, 200, 128, 64));
    send_pixel(make_pixel(255, 255, 255, 1, 255, 255, 255, 1, 255));
    send_pixel(make_pixel(170, 170, 170, 170, 85, 85, 85, 85, 85));
    send_pixel(make_pixel(85, 85, 85, 85, 170, 170, 170, 170, 170));
    send_pixel(make_pixel(255, 255, 255, 254, 255, 255, 255, 254, 0));

    // random bursts with random gaps, some bursts back to back
    burst_left = 0;
    for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_pixel(random_pixel());
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Blended %0d pixels: %0d opaque mixes, %0d over blends, %0d zero-alpha.",
             sb.pixels_out, sb.opaque_mixes, sb.over_blends, sb.clear_blends);
    $display("%0d colour lanes saturated; output held off %0d cycles once while input ran.",
             sb.clamped_lanes, HOLD_OFF_CYCLES);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
